### design/gha_pkg.sv
`default_nettype none

package gha_pkg;

   // request codes
   localparam logic [1:0] REQ_ALLOC  = 2'd0;
   localparam logic [1:0] REQ_FREE   = 2'd1;
   localparam logic [1:0] REQ_LOOKUP = 2'd2;
   localparam logic [1:0] REQ_CLEAR  = 2'd3;

   // response status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_INVALID = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;

   localparam logic [12:0] RECORD_MAX = 13'd4096;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [7:0]  handle_id;
      logic [15:0] handle_gen;
   } req_word_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  out_id;
      logic [15:0] out_gen;
      logic [19:0] byte_offset;
   } rsp_word_type;

endpackage

`default_nettype wire

### design/gha_core.sv
`default_nettype none

module gha_core import gha_pkg::*; #(
   parameter int MAX_SLOTS,
   parameter int GEN_BITS
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         issue,
   input  wire logic                         commit,
   input  wire req_word_type                 req,
   input  wire logic [12:0]                  record_bytes,
   output rsp_word_type                      rsp,
   output logic [$clog2(MAX_SLOTS):0]        free_count,
   output logic [$clog2(MAX_SLOTS):0]        high_water
);

   localparam int SLOT_W = $clog2(MAX_SLOTS);
   localparam int CNT_W  = SLOT_W + 1;
   localparam int IDX_W  = (CNT_W > 8) ? CNT_W : 8;
   localparam int CMP_W  = (GEN_BITS > 16) ? GEN_BITS : 16;

   // slot entry: {occupied, generation}; stack entry: {id, generation}
   logic [GEN_BITS:0]            slot_mem [MAX_SLOTS];
   logic [SLOT_W+GEN_BITS-1:0]   stk_mem  [MAX_SLOTS];

   req_word_type                 req_ff;
   logic [GEN_BITS:0]            slot_rd_ff;
   logic [SLOT_W+GEN_BITS-1:0]   stk_rd_ff;
   logic [CNT_W-1:0]             fc_ff, fc_in;
   logic [CNT_W-1:0]             hw_ff, hw_in;

   logic                         slot_we;
   logic [SLOT_W-1:0]            slot_wa;
   logic [GEN_BITS:0]            slot_wd;
   logic                         stk_we;
   logic [SLOT_W-1:0]            stk_wa;
   logic [SLOT_W+GEN_BITS-1:0]   stk_wd;

   logic                         slot_occ;
   logic [GEN_BITS-1:0]          slot_gen;
   logic [GEN_BITS-1:0]          gen_next;
   logic [SLOT_W-1:0]            stk_id;
   logic [GEN_BITS-1:0]          stk_gen;
   logic                         handle_ok;
   logic [19:0]                  prod;

   assign slot_occ = slot_rd_ff[GEN_BITS];
   assign slot_gen = slot_rd_ff[GEN_BITS-1:0];
   assign gen_next = slot_gen + GEN_BITS'(1);
   assign stk_id   = stk_rd_ff[SLOT_W+GEN_BITS-1:GEN_BITS];
   assign stk_gen  = stk_rd_ff[GEN_BITS-1:0];

   // ids at or above the high-water mark were never handed out
   assign handle_ok = (IDX_W'(req_ff.handle_id) < IDX_W'(hw_ff)) && slot_occ &&
                      (CMP_W'(slot_gen) == CMP_W'(req_ff.handle_gen));

   assign prod = 20'(req_ff.handle_id) * 20'(record_bytes);

   always_comb begin
      fc_in   = fc_ff;
      hw_in   = hw_ff;
      slot_we = 1'b0;
      slot_wa = SLOT_W'(req_ff.handle_id);
      slot_wd = {1'b0, gen_next};
      stk_we  = 1'b0;
      stk_wa  = fc_ff[SLOT_W-1:0];
      stk_wd  = {SLOT_W'(req_ff.handle_id), gen_next};
      rsp     = '0;
      unique case (req_ff.req_type)
         REQ_ALLOC: begin
            if (fc_ff != '0) begin
               // pop the most recently freed slot
               fc_in       = fc_ff - CNT_W'(1);
               slot_we     = 1'b1;
               slot_wa     = stk_id;
               slot_wd     = {1'b1, stk_gen};
               rsp.out_id  = 8'(stk_id);
               rsp.out_gen = 16'(stk_gen);
            end else if (hw_ff < CNT_W'(MAX_SLOTS)) begin
               hw_in      = hw_ff + CNT_W'(1);
               slot_we    = 1'b1;
               slot_wa    = hw_ff[SLOT_W-1:0];
               slot_wd    = {1'b1, {GEN_BITS{1'b0}}};
               rsp.out_id = 8'(hw_ff[SLOT_W-1:0]);
            end else begin
               rsp.status = ST_FULL;
            end
         end
         REQ_FREE: begin
            if (handle_ok) begin
               slot_we = 1'b1;
               if (fc_ff < CNT_W'(MAX_SLOTS)) begin
                  stk_we = 1'b1;
                  fc_in  = fc_ff + CNT_W'(1);
               end
            end else begin
               rsp.status = ST_INVALID;
            end
         end
         REQ_LOOKUP: begin
            if (handle_ok) begin
               rsp.byte_offset = prod;
            end else begin
               rsp.status = ST_INVALID;
            end
         end
         REQ_CLEAR: begin
            fc_in = '0;
            hw_in = '0;
         end
         default: begin
            rsp.status = ST_INVALID;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fc_ff <= '0;
         hw_ff <= '0;
      end else if (commit) begin
         fc_ff <= fc_in;
         hw_ff <= hw_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         req_ff <= req;
      end
   end

   always_ff @(posedge clock) begin
      if (commit && slot_we) begin
         slot_mem[slot_wa] <= slot_wd;
      end
      if (issue) begin
         slot_rd_ff <= slot_mem[SLOT_W'(req.handle_id)];
      end
   end

   // read the stack top speculatively; only allocate uses it
   always_ff @(posedge clock) begin
      if (commit && stk_we) begin
         stk_mem[stk_wa] <= stk_wd;
      end
      if (issue) begin
         stk_rd_ff <= stk_mem[SLOT_W'(fc_ff - CNT_W'(1))];
      end
   end

   assign free_count = fc_ff;
   assign high_water = hw_ff;

endmodule

`default_nettype wire

### design/generational_handle_allocator_top.sv
// Generational handle allocator: hands out handles made of a slot id and a
// generation, and checks them on free and lookup.
// Request channel (req_valid / req_stall): req_type selects allocate, free,
// lookup or clear; req_handle_id and req_handle_gen carry the handle.
// Response channel (rsp_valid / rsp_stall): exactly one word per request
// with status, allocated id and generation, and the lookup byte offset.
// csr_wr_en / csr_wr_data set the record size; values above 4096 saturate.
// Each request first reads the slot table and free stack, then checks and
// writes back. The response is registered at the write-back edge, and a new
// request is taken only after the previous one has written back.
// The read-then-write of the single-port slot memory keeps requests from
// overlapping.
// When rsp_stall holds a waiting word, one more request can be accepted
// and parks in its write-back cycle until the output register frees.
// Reset empties the map at once (counters to zero, no memory sweep) and
// sets the record size to 1.
`default_nettype none

module generational_handle_allocator_top import gha_pkg::*; #(
   parameter int MAX_SLOTS = 256,
   parameter int GEN_BITS  = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_type,
   input  wire logic [7:0]  req_handle_id,
   input  wire logic [15:0] req_handle_gen,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_status,
   output logic [7:0]       rsp_out_id,
   output logic [15:0]      rsp_out_gen,
   output logic [19:0]      rsp_byte_offset,
   input  wire logic        csr_wr_en,
   input  wire logic [12:0] csr_wr_data
);

   localparam int CNT_W = $clog2(MAX_SLOTS) + 1;

   localparam logic FSM_IDLE = 1'b0;
   localparam logic FSM_EXEC = 1'b1;

   logic               state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_word_type       rsp_word_ff;
   rsp_word_type       core_rsp;
   req_word_type       req_word;
   logic [12:0]        record_bytes_ff;
   logic               accept;
   logic               commit;
   logic [CNT_W-1:0]   free_count;
   logic [CNT_W-1:0]   high_water;

   assign req_word  = '{req_type: req_type, handle_id: req_handle_id,
                        handle_gen: req_handle_gen};
   assign req_stall = (state_ff != FSM_IDLE);
   assign accept    = req_valid && !req_stall;
   assign commit    = (state_ff == FSM_EXEC) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FSM_IDLE: begin
            if (accept) begin
               state_in = FSM_EXEC;
            end
         end
         FSM_EXEC: begin
            if (commit) begin
               state_in = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= FSM_IDLE;
         rsp_valid_ff    <= 1'b0;
         record_bytes_ff <= 13'd1;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            record_bytes_ff <= (csr_wr_data > RECORD_MAX) ? RECORD_MAX : csr_wr_data;
         end
      end
   end

   // hold the word until taken
   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_word_ff <= core_rsp;
      end
   end

   gha_core #(
      .MAX_SLOTS (MAX_SLOTS),
      .GEN_BITS  (GEN_BITS)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .issue        (accept),
      .commit       (commit),
      .req          (req_word),
      .record_bytes (record_bytes_ff),
      .rsp          (core_rsp),
      .free_count   (free_count),
      .high_water   (high_water)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_word_ff.status;
   assign rsp_out_id      = rsp_word_ff.out_id;
   assign rsp_out_gen     = rsp_word_ff.out_gen;
   assign rsp_byte_offset = rsp_word_ff.byte_offset;

   a_two_cycle_issue: assert property (@(posedge clock) disable iff (reset)
      accept |=> !accept)
      else $error("request accepted in back-to-back cycles");

   a_free_below_hw: assert property (@(posedge clock) disable iff (reset)
      free_count <= high_water)
      else $error("free stack deeper than high-water mark");

   a_hw_in_range: assert property (@(posedge clock) disable iff (reset)
      high_water <= CNT_W'(MAX_SLOTS))
      else $error("high-water mark beyond capacity");

   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ST_OK)) |->
         (rsp_out_id == 8'd0) && (rsp_out_gen == 16'd0) && (rsp_byte_offset == 20'd0))
      else $error("failed response carries payload");

endmodule

`default_nettype wire
